[hdl/atilt_pkg.sv]
`default_nettype none
package atilt_pkg;

	// working widths of the rotation datapath
	localparam int X_W       = 34;
	localparam int ANG_W     = 32;
	localparam int WORK_FRAC = 20;
	localparam int IN_SCALE  = 14;
	localparam int OUT_W     = 17;
	localparam int TABLE_LEN = 24;
	localparam int MAG_W     = 31;
	localparam int GSPLIT    = 15;

	// 1/K in Q30, split into two halves for the multiplier
	localparam logic [29:0] GAIN_INV = 30'd652032874;
	localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 <<< WORK_FRAC);

	// which vector travels through the row
	typedef enum logic [1:0] {
		OP_MAG   = 2'd0,
		OP_ROLL  = 2'd1,
		OP_PITCH = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISS_ROLL,
		ST_WAIT_MAG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ISS_PITCH,
		ST_WAIT_PITCH,
		ST_FIN
	} state_t;

	// one word handed from cell to cell
	typedef struct packed {
		logic                    vld;
		op_t                     op;
		logic                    zero;
		logic signed [X_W-1:0]   x;
		logic signed [X_W-1:0]   y;
		logic signed [ANG_W-1:0] ang;
	} cell_t;

	// atan(2^-i) in degrees scaled by 2^20
	function automatic logic signed [ANG_W-1:0] atan_ent(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0:  r = 32'sd47185920;
			1:  r = 32'sd27855475;
			2:  r = 32'sd14718068;
			3:  r = 32'sd7471121;
			4:  r = 32'sd3750058;
			5:  r = 32'sd1876857;
			6:  r = 32'sd938658;
			7:  r = 32'sd469357;
			8:  r = 32'sd234682;
			9:  r = 32'sd117342;
			10: r = 32'sd58671;
			11: r = 32'sd29335;
			12: r = 32'sd14668;
			13: r = 32'sd7334;
			14: r = 32'sd3667;
			15: r = 32'sd1833;
			16: r = 32'sd917;
			17: r = 32'sd458;
			18: r = 32'sd229;
			19: r = 32'sd115;
			20: r = 32'sd57;
			21: r = 32'sd29;
			22: r = 32'sd14;
			23: r = 32'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/atilt_cell.sv]
`default_nettype none
module atilt_cell #(
	parameter int SHIFT = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  atilt_pkg::cell_t    din,
	output atilt_pkg::cell_t    dout
);
	import atilt_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_ent(SHIFT);

	cell_t nxt;

	// one vectoring micro-rotation, driving y towards zero
	always_comb begin
		logic signed [X_W-1:0] dx;
		logic signed [X_W-1:0] dy;
		dx = din.y >>> SHIFT;
		dy = din.x >>> SHIFT;
		nxt = din;
		if (din.y > 0) begin
			nxt.x   = din.x + dx;
			nxt.y   = din.y - dy;
			nxt.ang = din.ang + ATAN;
		end else begin
			nxt.x   = din.x - dx;
			nxt.y   = din.y + dy;
			nxt.ang = din.ang - ATAN;
		end
	end

	// cell register, valid flag and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

[hdl/atilt_chain.sv]
`default_nettype none
module atilt_chain #(
	parameter int STAGES = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  atilt_pkg::cell_t    din,
	output atilt_pkg::cell_t    dout
);
	import atilt_pkg::*;

	cell_t link [0:STAGES];

	assign link[0] = din;

	// row of rotation cells, cell i shifts by i
	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		atilt_cell #(.SHIFT(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign dout = link[STAGES];

endmodule
`default_nettype wire

[hdl/accel_tilt_angles_with_offset.sv]
`default_nettype none
// Tilt angles from a raw accelerometer sample, with stored zero offsets.
// Input stream: s_tdata carries accel_x, accel_y, accel_z (16-bit signed
// each); s_tuser is the action, 0 = measure, 1 = calibrate.
// Output stream: m_tdata carries x_tilt (negated pitch minus its offset) and
// y_tilt (roll minus its offset), 17-bit signed at 2^-ANGLE_FRAC_BITS degree.
// A calibrate word stores both angles as offsets and produces no output.
// All three atan2 evaluations share one row of CORDIC_STAGES rotation cells:
// the magnitude and roll vectors enter on consecutive cycles, the magnitude
// is gain-corrected by a two-pass 31x15 multiply, then the pitch vector goes
// through the row. A new word is taken only once the previous one has
// left the row. s_tready is high only when the sequencer is idle.
// If the receiver stalls, the finished result sits in the output register;
// the next word may be accepted, and a measure word is held at its final
// step until the register empties. Reset clears both offsets to zero and
// empties the row and the output register.
module accel_tilt_angles_with_offset #(
	parameter int CORDIC_STAGES   = 16,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // accel_x, accel_y, accel_z
	input  wire  [0:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata    // x_tilt, y_tilt, zero pad
);
	import atilt_pkg::*;

	localparam int SH    = WORK_FRAC - ANGLE_FRAC_BITS;
	localparam int OFS_W = ANGLE_FRAC_BITS + 9;
	localparam logic signed [ANG_W-1:0] RND  = ANG_W'(1 <<< (SH - 1));
	localparam logic signed [ANG_W-1:0] PLIM = ANG_W'(90 <<< ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] RLIM = ANG_W'(180 <<< ANGLE_FRAC_BITS);

	state_t st_q, st_d;

	logic                    act_q;
	logic signed [X_W-1:0]   ax_q, ay_q, az_q;
	logic [MAG_W-1:0]        mag_q;
	logic [MAG_W+GSPLIT-1:0] plo_q, phi_q;
	logic signed [ANG_W-1:0] roll_ang_q, pitch_ang_q;
	logic signed [OFS_W-1:0] pofs_q, rofs_q;

	cell_t entry, chain_out;
	logic  accept;
	logic  out_load;

	logic signed [X_W-1:0]   in_x, in_z;
	logic signed [X_W-1:0]   ey, ex;
	op_t                     eop;
	logic                    evld;
	logic [MAG_W+2*GSPLIT:0] msum;
	logic [MAG_W+2*GSPLIT:0] mtot;
	logic signed [X_W-1:0]   mag2;
	logic signed [ANG_W-1:0] p_rnd, r_rnd;
	logic signed [OFS_W-1:0] pitch, roll;
	logic signed [ANG_W-1:0] xd, yd;

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_x     = X_W'($signed(s_tdata[15:0])) <<< IN_SCALE;
	assign in_z     = X_W'($signed(s_tdata[47:32])) <<< IN_SCALE;

	// gain-corrected magnitude from the two partial products
	assign msum = (MAG_W+2*GSPLIT+1)'(phi_q) << GSPLIT;
	assign mtot = msum + (MAG_W+2*GSPLIT+1)'(plo_q);
	assign mag2 = $signed(X_W'(mtot >> 30));

	// vector source for the row
	always_comb begin
		ey   = in_x;
		ex   = in_z;
		eop  = OP_MAG;
		evld = 1'b0;
		case (st_q)
			ST_IDLE: begin
				evld = accept;
			end
			ST_ISS_ROLL: begin
				ey   = -ax_q;
				ex   = az_q;
				eop  = OP_ROLL;
				evld = 1'b1;
			end
			ST_ISS_PITCH: begin
				ey   = ay_q;
				ex   = mag2;
				eop  = OP_PITCH;
				evld = 1'b1;
			end
			default: evld = 1'b0;
		endcase
	end

	// quadrant pre-rotation into the right half plane
	always_comb begin
		entry.vld  = evld;
		entry.op   = eop;
		entry.zero = (ex == '0) && (ey == '0);
		entry.x    = ex;
		entry.y    = ey;
		entry.ang  = '0;
		if (ex < 0) begin
			if (ey >= 0) begin
				entry.x   = ey;
				entry.y   = -ex;
				entry.ang = DEG90;
			end else begin
				entry.x   = -ey;
				entry.y   = ex;
				entry.ang = -DEG90;
			end
		end
	end

	atilt_chain #(.STAGES(CORDIC_STAGES)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (entry),
		.dout   (chain_out)
	);

	// round and clamp the final angles
	always_comb begin
		p_rnd = (pitch_ang_q + RND) >>> SH;
		r_rnd = (roll_ang_q + RND) >>> SH;
		if (p_rnd > PLIM) p_rnd = PLIM;
		if (p_rnd < -PLIM) p_rnd = -PLIM;
		if (r_rnd > RLIM) r_rnd = RLIM;
		if (r_rnd < -RLIM) r_rnd = -RLIM;
		pitch = p_rnd[OFS_W-1:0];
		roll  = r_rnd[OFS_W-1:0];
		xd    = ANG_W'(pofs_q) - ANG_W'(pitch);
		yd    = ANG_W'(roll) - ANG_W'(rofs_q);
	end

	// sequencer
	always_comb begin
		st_d     = st_q;
		out_load = 1'b0;
		case (st_q)
			ST_IDLE:       if (accept) st_d = ST_ISS_ROLL;
			ST_ISS_ROLL:   st_d = ST_WAIT_MAG;
			ST_WAIT_MAG:   if (chain_out.vld && chain_out.op == OP_MAG) st_d = ST_MUL_LO;
			ST_MUL_LO:     st_d = ST_MUL_HI;
			ST_MUL_HI:     st_d = ST_ISS_PITCH;
			ST_ISS_PITCH:  st_d = ST_WAIT_PITCH;
			ST_WAIT_PITCH: if (chain_out.vld && chain_out.op == OP_PITCH) st_d = ST_FIN;
			ST_FIN: begin
				if (act_q) begin
					st_d = ST_IDLE;
				end else if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sample capture and intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_tuser[0];
			ax_q  <= in_x;
			ay_q  <= X_W'($signed(s_tdata[31:16])) <<< IN_SCALE;
			az_q  <= in_z;
		end
		if (chain_out.vld && chain_out.op == OP_MAG)
			mag_q <= chain_out.zero ? '0 : chain_out.x[MAG_W-1:0];
		if (chain_out.vld && chain_out.op == OP_ROLL)
			roll_ang_q <= chain_out.zero ? '0 : chain_out.ang;
		if (chain_out.vld && chain_out.op == OP_PITCH)
			pitch_ang_q <= chain_out.zero ? '0 : chain_out.ang;
		if (st_q == ST_MUL_LO)
			plo_q <= (MAG_W+GSPLIT)'(mag_q) * (MAG_W+GSPLIT)'(GAIN_INV[GSPLIT-1:0]);
		if (st_q == ST_MUL_HI)
			phi_q <= (MAG_W+GSPLIT)'(mag_q) * (MAG_W+GSPLIT)'(GAIN_INV[2*GSPLIT-1:GSPLIT]);
	end

	// stored offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pofs_q <= '0;
			rofs_q <= '0;
		end else if (st_q == ST_FIN && act_q) begin
			pofs_q <= pitch;
			rofs_q <= roll;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata <= {6'b0, yd[OUT_W-1:0], xd[OUT_W-1:0]};
	end

`ifndef SYNTHESIS
	a_idle_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !chain_out.vld)
		else $error("row not empty while idle");

	a_roll_follows_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_out.vld && chain_out.op == OP_MAG) |=>
		(chain_out.vld && chain_out.op == OP_ROLL))
		else $error("roll vector did not follow magnitude");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && !act_q && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("measure result not presented");

	a_cal_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && act_q && !m_tvalid) |=> !m_tvalid)
		else $error("calibrate produced output");
`endif

endmodule
`default_nettype wire

[tb/tb_accel_tilt_angles_with_offset.sv]
`default_nettype none
module tb_accel_tilt_angles_with_offset;
	timeunit 1ns;
	timeprecision 1ps;
	import atilt_pkg::*;

	localparam int STAGES    = 16;
	localparam int FRAC      = 7;
	localparam int TBL       = 24;
	localparam int RUN_LIMIT = 200000;
	localparam logic ACT_MEASURE   = 1'b0;
	localparam logic ACT_CALIBRATE = 1'b1;

	// packed to match {s_tuser, s_tdata}, accel_x in the lowest bits
	typedef struct packed {
		logic               action;
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
	} sample_t;

	// packed to match m_tdata[33:0], x_tilt in the lowest bits
	typedef struct packed {
		logic signed [16:0] y_tilt;
		logic signed [16:0] x_tilt;
	} tilt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // accel_x, accel_y, accel_z
	logic [0:0]  s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // x_tilt, y_tilt, zero pad

	accel_tilt_angles_with_offset dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	sample_t pending_samples[$];
	tilt_t   expected_tilts[$];
	longint  pitch_off, roll_off;
	int      mismatches;
	int      send_idle_pct, recv_idle_pct;
	int      hold_cycles;
	longint  cycle_count;
	bit      s_tready_seen;

	// arctangent table, 2^-20 degree
	const longint atan_deg[TBL] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7};

	// vectoring rotation: returns angle, magnitude through mag_out
	function automatic longint vector_angle(longint y, longint x, output longint mag_out);
		longint ang, t, dx, dy;
		int n;
		ang = 0;
		n = (STAGES > TBL) ? TBL : STAGES;
		if (x == 0 && y == 0) begin
			mag_out = 0;
			return 0;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; ang = 90 * 1048576;
			end else begin
				t = x; x = -y; y = t; ang = -90 * 1048576;
			end
		end
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; ang += atan_deg[i];
			end else begin
				x -= dx; y += dy; ang -= atan_deg[i];
			end
		end
		mag_out = x;
		return ang;
	endfunction

	// round to output units and clamp
	function automatic longint angle_units(longint ang, longint lim_deg);
		int s;
		longint r, lim;
		s = 20 - FRAC;
		r = (ang + (longint'(1) <<< (s - 1))) >>> s;
		lim = lim_deg <<< FRAC;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	// update offsets, queue the tilt a measure word should produce
	function automatic void predict_tilt(sample_t smp);
		longint ax, ay, az, mag, scratch, pitch, roll;
		tilt_t t;
		ax = longint'(smp.ax) * 16384;
		ay = longint'(smp.ay) * 16384;
		az = longint'(smp.az) * 16384;
		void'(vector_angle(ax, az, mag));
		mag = (mag * 652032874) >>> 30;
		pitch = angle_units(vector_angle(ay, mag, scratch), 90);
		roll = angle_units(vector_angle(-ax, az, scratch), 180);
		if (smp.action == ACT_CALIBRATE) begin
			pitch_off = pitch;
			roll_off = roll;
		end else begin
			t.x_tilt = 17'(pitch_off - pitch);
			t.y_tilt = 17'(roll - roll_off);
			expected_tilts.push_back(t);
		end
	endfunction

	function automatic sample_t rand_sample(logic act);
		sample_t s;
		int sel;
		s.action = act;
		sel = $urandom_range(0, 9);
		s.ax = 16'($urandom);
		s.ay = 16'($urandom);
		s.az = 16'($urandom);
		// sometimes small or zero components to reach the near-axis cases
		if (sel == 0) s.ax = 0;
		if (sel == 1) s.az = 0;
		if (sel == 2) begin
			s.ax = 16'($urandom_range(0, 15)) - 16'sd8;
			s.ay = 16'($urandom_range(0, 15)) - 16'sd8;
		end
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sender: one word per handshake, changes on falling edge
	always @(negedge clk) begin
		if (s_tvalid && s_tready_seen) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tdata} <= pending_samples.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end else if (!s_tvalid && arst_n) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tdata} <= pending_samples.pop_front();
			end
		end
	end

	always @(posedge clk) begin
		s_tready_seen <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) predict_tilt(sample_t'({s_tuser, s_tdata}));
	end

	// receiver back-pressure, with an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// checker
	always @(posedge clk) begin
		tilt_t got, want;
		got = tilt_t'(m_tdata[33:0]);
		if (m_tvalid && m_tready) begin
			if (expected_tilts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word x=%0d y=%0d", got.x_tilt, got.y_tilt);
			end else begin
				want = expected_tilts.pop_front();
				if (got.x_tilt !== want.x_tilt || got.y_tilt !== want.y_tilt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tilt mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
							want.x_tilt, want.y_tilt, got.x_tilt, got.y_tilt);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_directed(logic act, int x, int y, int z);
		sample_t s;
		s.action = act;
		s.ax = 16'(x);
		s.ay = 16'(y);
		s.az = 16'(z);
		pending_samples.push_back(s);
	endtask

	task automatic drain_words();
		while (pending_samples.size() != 0 || s_tvalid || expected_tilts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		s_tready_seen = 1'b0;
		pitch_off = 0;
		roll_off = 0;
		mismatches = 0;
		hold_cycles = 0;
		cycle_count = 0;
		send_idle_pct = 27;
		recv_idle_pct = 73;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: zero vector, axes, extremes, zero over negative, calibrations
		add_directed(ACT_MEASURE, 0, 0, 0);
		add_directed(ACT_MEASURE, 0, 0, -32768);
		add_directed(ACT_MEASURE, 0, 100, -1);
		add_directed(ACT_MEASURE, 32767, 32767, 32767);
		add_directed(ACT_MEASURE, -32768, -32768, -32768);
		add_directed(ACT_MEASURE, -32768, 0, 0);
		add_directed(ACT_MEASURE, 32767, 0, 0);
		add_directed(ACT_MEASURE, 0, 32767, 0);
		add_directed(ACT_MEASURE, 0, -32768, 0);
		add_directed(ACT_MEASURE, 0, 0, 32767);
		add_directed(ACT_MEASURE, 1, -1, 1);
		add_directed(ACT_CALIBRATE, 1000, -2000, 16000);
		add_directed(ACT_MEASURE, 0, 0, 16384);
		add_directed(ACT_MEASURE, -16384, 16384, 0);
		add_directed(ACT_CALIBRATE, -32768, 32767, -32768);
		add_directed(ACT_MEASURE, 32767, -32768, -1);
		add_directed(ACT_MEASURE, -1, -1, -1);
		add_directed(ACT_CALIBRATE, 0, 0, 0);
		add_directed(ACT_MEASURE, 5, 7, 9);
		drain_words();

		// random phases with changing idle patterns
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 73; recv_idle_pct = 27;
			end else if (ph == 2) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			for (int i = 0; i < 150; i++)
				pending_samples.push_back(rand_sample(
					($urandom_range(0, 9) == 0) ? ACT_CALIBRATE : ACT_MEASURE));
			// long receiver stall while words keep coming
			if (ph == 2) hold_cycles = 400;
			drain_words();
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_tilts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

[accel_tilt_angles_with_offset.f]
hdl/atilt_pkg.sv
hdl/atilt_cell.sv
hdl/atilt_chain.sv
hdl/accel_tilt_angles_with_offset.sv
tb/tb_accel_tilt_angles_with_offset.sv
